// ----- sv/gapc_pkg.sv -----
// Shared types and constants for the gap aiming PID controller.
// Used by the channel interfaces, the axis datapath, the top level and the checker.
package gapc_pkg;

  localparam int unsigned PixW   = 10;
  localparam int unsigned ErrW   = PixW + 1;   // signed pixel error
  localparam int unsigned DErrW  = ErrW + 1;   // signed error difference
  localparam int unsigned SumW   = 32;         // saturating error sum
  localparam int unsigned GainW  = 16;
  localparam int unsigned SpeedW = 15;
  localparam int unsigned VelW   = 16;
  localparam int unsigned CntW   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned PropW = GainW + 1 + ErrW;
  localparam int unsigned DerW  = GainW + 1 + DErrW;
  localparam int unsigned IntW  = GainW + 1 + SumW;
  localparam int unsigned AccW  = IntW + 1;

  localparam logic [CntW-1:0] SEEN_LIMIT = 4'd10;
  localparam logic [CntW-1:0] SEEN_MAX   = 4'd15;

  localparam logic [GainW-1:0]  RST_GAIN_PROP     = 16'd2048;
  localparam logic [GainW-1:0]  RST_GAIN_INTEGRAL = 16'd20;
  localparam logic [GainW-1:0]  RST_GAIN_DERIV    = 16'd205;
  localparam logic [SpeedW-1:0] RST_SPEED_LIMIT   = 15'd1229;
  localparam logic [PixW-1:0]   RST_AIM_THRESHOLD = 10'd20;
  localparam logic [SpeedW-1:0] RST_GAP_SPEED     = 15'd410;
  localparam logic [PixW-1:0]   RST_AIM_CENTER_X  = 10'd476;
  localparam logic [PixW-1:0]   RST_AIM_CENTER_Y  = 10'd356;

  typedef enum logic [1:0] {
    MODE_HOVER = 2'd0,
    MODE_AIM   = 2'd1,
    MODE_FLY   = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEGRAL = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_SPEED_LIMIT   = 3'd3,
    REG_AIM_THRESHOLD = 3'd4,
    REG_GAP_SPEED     = 3'd5,
    REG_AIM_CENTER_X  = 3'd6,
    REG_AIM_CENTER_Y  = 3'd7
  } cfg_reg_e;

  // pipeline load enables handed to the axis datapath
  typedef struct packed {
    logic load_prod;
    logic load_out;
  } pipe_ctl_t;

endpackage

// ----- sv/gapc_in_if.sv -----
// Input channel: one camera frame detection per transfer.
// Depends on gapc_pkg for field widths.
interface gapc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       target_seen;
  logic [gapc_pkg::PixW-1:0]  target_x;
  logic [gapc_pkg::PixW-1:0]  target_y;

  modport source (output valid, output target_seen, output target_x, output target_y,
                  input ready);
  modport sink   (input valid, input target_seen, input target_x, input target_y,
                  output ready);
  modport monitor (input valid, input ready, input target_seen, input target_x,
                   input target_y);
endinterface

// ----- sv/gapc_out_if.sv -----
// Output channel: flight mode and velocity command per transfer.
// Depends on gapc_pkg for field widths.
interface gapc_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        flight_mode;
  logic [gapc_pkg::SpeedW-1:0]       vel_forward;
  logic signed [gapc_pkg::VelW-1:0]  vel_lateral;
  logic signed [gapc_pkg::VelW-1:0]  vel_vertical;

  modport source (output valid, output flight_mode, output vel_forward,
                  output vel_lateral, output vel_vertical, input ready);
  modport sink   (input valid, input flight_mode, input vel_forward,
                  input vel_lateral, input vel_vertical, output ready);
  modport monitor (input valid, input ready, input flight_mode, input vel_forward,
                   input vel_lateral, input vel_vertical);
endinterface

// ----- sv/gap_aim_pid_controller_core.sv -----
// Gap aiming PID controller: detection state, error sums, two PID axes, clamp.
// Depends on gapc_pkg, gapc_in_if, gapc_out_if and gapc_axis.
// Pipeline: an input transfer passes the input register, the products, then sum and
// clamp into the result register. Throughput: one item per cycle; input stalls only when
// all three stages hold items and the output is not taken.
// Reset (async, active low) clears the valid bits and the controller state and
// loads the register defaults.
module gap_aim_pid_controller_core #(
  parameter logic [gapc_pkg::CntW-1:0] SeenLimit = gapc_pkg::SEEN_LIMIT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gapc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gapc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  gapc_in_if.sink                        target_i,
  gapc_out_if.source                     result_o
);

  // configuration registers
  logic [gapc_pkg::GainW-1:0]  gain_prop_q, gain_integral_q, gain_deriv_q;
  logic [gapc_pkg::SpeedW-1:0] speed_limit_q, gap_speed_q;
  logic [gapc_pkg::PixW-1:0]   aim_threshold_q, aim_center_x_q, aim_center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q     <= gapc_pkg::RST_GAIN_PROP;
      gain_integral_q <= gapc_pkg::RST_GAIN_INTEGRAL;
      gain_deriv_q    <= gapc_pkg::RST_GAIN_DERIV;
      speed_limit_q   <= gapc_pkg::RST_SPEED_LIMIT;
      aim_threshold_q <= gapc_pkg::RST_AIM_THRESHOLD;
      gap_speed_q     <= gapc_pkg::RST_GAP_SPEED;
      aim_center_x_q  <= gapc_pkg::RST_AIM_CENTER_X;
      aim_center_y_q  <= gapc_pkg::RST_AIM_CENTER_Y;
    end else if (cfg_we_i) begin
      case (gapc_pkg::cfg_reg_e'(cfg_idx_i))
        gapc_pkg::REG_GAIN_PROP:     gain_prop_q     <= cfg_wdata_i;
        gapc_pkg::REG_GAIN_INTEGRAL: gain_integral_q <= cfg_wdata_i;
        gapc_pkg::REG_GAIN_DERIV:    gain_deriv_q    <= cfg_wdata_i;
        gapc_pkg::REG_SPEED_LIMIT:   speed_limit_q   <= cfg_wdata_i[gapc_pkg::SpeedW-1:0];
        gapc_pkg::REG_AIM_THRESHOLD: aim_threshold_q <= cfg_wdata_i[gapc_pkg::PixW-1:0];
        gapc_pkg::REG_GAP_SPEED:     gap_speed_q     <= cfg_wdata_i[gapc_pkg::SpeedW-1:0];
        gapc_pkg::REG_AIM_CENTER_X:  aim_center_x_q  <= cfg_wdata_i[gapc_pkg::PixW-1:0];
        gapc_pkg::REG_AIM_CENTER_Y:  aim_center_y_q  <= cfg_wdata_i[gapc_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: each stage loads when it is empty or the one after it can take its item
  logic v1_q, v2_q, v3_q;
  logic s3_ok, s2_ok, in_ready, in_xfer;

  assign s3_ok    = !v3_q || result_o.ready;
  assign s2_ok    = !v2_q || s3_ok;
  assign in_ready = !v1_q || s2_ok;
  assign in_xfer  = target_i.valid && in_ready;
  assign target_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready) v1_q <= target_i.valid;
      if (s2_ok)    v2_q <= v1_q;
      if (s3_ok)    v3_q <= v2_q;
    end
  end

  // controller state, updated on the input transfer itself
  logic [gapc_pkg::CntW-1:0]         seen_cnt_q, seen_cnt_d;
  logic signed [gapc_pkg::ErrW-1:0]  prev_lat_q, prev_vert_q;
  logic signed [gapc_pkg::SumW-1:0]  sum_lat_q, sum_vert_q, sum_lat_d, sum_vert_d;
  logic signed [gapc_pkg::ErrW-1:0]  err_lat, err_vert;
  logic signed [gapc_pkg::DErrW-1:0] derr_lat, derr_vert;
  logic [gapc_pkg::ErrW-1:0]         mag_lat, mag_vert;
  logic                              active, aim;
  gapc_pkg::mode_e                   mode_d;

  function automatic logic signed [gapc_pkg::SumW-1:0] sat_add(
    input logic signed [gapc_pkg::SumW-1:0] a,
    input logic signed [gapc_pkg::ErrW-1:0] b
  );
    logic signed [gapc_pkg::SumW:0] s;
    s = {a[gapc_pkg::SumW-1], a} + (gapc_pkg::SumW + 1)'(b);
    if (s[gapc_pkg::SumW] != s[gapc_pkg::SumW-1]) begin
      // overflow: sign of the true sum is the top bit
      return {s[gapc_pkg::SumW], {(gapc_pkg::SumW - 1){!s[gapc_pkg::SumW]}}};
    end
    return s[gapc_pkg::SumW-1:0];
  endfunction

  always_comb begin
    err_lat  = signed'({1'b0, target_i.target_x}) - signed'({1'b0, aim_center_x_q});
    err_vert = signed'({1'b0, aim_center_y_q}) - signed'({1'b0, target_i.target_y});
    derr_lat  = gapc_pkg::DErrW'(err_lat) - gapc_pkg::DErrW'(prev_lat_q);
    derr_vert = gapc_pkg::DErrW'(err_vert) - gapc_pkg::DErrW'(prev_vert_q);
    mag_lat  = err_lat[gapc_pkg::ErrW-1]  ? unsigned'(-err_lat)  : unsigned'(err_lat);
    mag_vert = err_vert[gapc_pkg::ErrW-1] ? unsigned'(-err_vert) : unsigned'(err_vert);
    sum_lat_d  = sat_add(sum_lat_q, err_lat);
    sum_vert_d = sat_add(sum_vert_q, err_vert);
    active = target_i.target_seen || (seen_cnt_q > SeenLimit);
    aim    = (mag_lat > {1'b0, aim_threshold_q}) && (mag_vert > {1'b0, aim_threshold_q});
    if (!active) begin
      mode_d = gapc_pkg::MODE_HOVER;
    end else if (aim) begin
      mode_d = gapc_pkg::MODE_AIM;
    end else begin
      mode_d = gapc_pkg::MODE_FLY;
    end
    seen_cnt_d = seen_cnt_q;
    if (target_i.target_seen && (seen_cnt_q != gapc_pkg::SEEN_MAX)) begin
      seen_cnt_d = seen_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_cnt_q  <= '0;
      prev_lat_q  <= '0;
      prev_vert_q <= '0;
      sum_lat_q   <= '0;
      sum_vert_q  <= '0;
    end else if (in_xfer) begin
      seen_cnt_q <= seen_cnt_d;
      if (active) begin
        prev_lat_q  <= err_lat;
        prev_vert_q <= err_vert;
        sum_lat_q   <= sum_lat_d;
        sum_vert_q  <= sum_vert_d;
      end
    end
  end

  // stage payload registers
  gapc_pkg::mode_e                   mode1_q, mode2_q, mode3_q;
  logic signed [gapc_pkg::ErrW-1:0]  err_lat1_q, err_vert1_q;
  logic signed [gapc_pkg::DErrW-1:0] derr_lat1_q, derr_vert1_q;
  logic signed [gapc_pkg::SumW-1:0]  sum_lat1_q, sum_vert1_q;
  logic [gapc_pkg::SpeedW-1:0]       fwd3_q;

  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      mode1_q      <= mode_d;
      err_lat1_q   <= err_lat;
      err_vert1_q  <= err_vert;
      derr_lat1_q  <= derr_lat;
      derr_vert1_q <= derr_vert;
      sum_lat1_q   <= sum_lat_d;
      sum_vert1_q  <= sum_vert_d;
    end
    if (s2_ok) begin
      mode2_q <= mode1_q;
    end
    if (s3_ok) begin
      mode3_q <= mode2_q;
      fwd3_q  <= (mode2_q == gapc_pkg::MODE_FLY) ? gap_speed_q : '0;
    end
  end

  gapc_pkg::pipe_ctl_t axis_ctl;
  logic signed [gapc_pkg::VelW-1:0] vel_lat, vel_vert;

  assign axis_ctl.load_prod = s2_ok;
  assign axis_ctl.load_out  = s3_ok;

  gapc_axis u_axis_lat (
    .clk_i           (clk_i),
    .ctl_i           (axis_ctl),
    .err_i           (err_lat1_q),
    .derr_i          (derr_lat1_q),
    .sum_i           (sum_lat1_q),
    .gain_prop_i     (gain_prop_q),
    .gain_integral_i (gain_integral_q),
    .gain_deriv_i    (gain_deriv_q),
    .speed_limit_i   (speed_limit_q),
    .vel_o           (vel_lat)
  );

  gapc_axis u_axis_vert (
    .clk_i           (clk_i),
    .ctl_i           (axis_ctl),
    .err_i           (err_vert1_q),
    .derr_i          (derr_vert1_q),
    .sum_i           (sum_vert1_q),
    .gain_prop_i     (gain_prop_q),
    .gain_integral_i (gain_integral_q),
    .gain_deriv_i    (gain_deriv_q),
    .speed_limit_i   (speed_limit_q),
    .vel_o           (vel_vert)
  );

  assign result_o.valid        = v3_q;
  assign result_o.flight_mode  = mode3_q;
  assign result_o.vel_forward  = fwd3_q;
  assign result_o.vel_lateral  = (mode3_q == gapc_pkg::MODE_AIM) ? vel_lat  : '0;
  assign result_o.vel_vertical = (mode3_q == gapc_pkg::MODE_AIM) ? vel_vert : '0;

endmodule

// ----- sv/gapc_axis.sv -----
// One axis of the PID: registered products, then sum and clamp into a result register.
// Depends on gapc_pkg.
module gapc_axis (
  input  logic                              clk_i,
  input  gapc_pkg::pipe_ctl_t               ctl_i,
  input  logic signed [gapc_pkg::ErrW-1:0]  err_i,
  input  logic signed [gapc_pkg::DErrW-1:0] derr_i,
  input  logic signed [gapc_pkg::SumW-1:0]  sum_i,
  input  logic [gapc_pkg::GainW-1:0]        gain_prop_i,
  input  logic [gapc_pkg::GainW-1:0]        gain_integral_i,
  input  logic [gapc_pkg::GainW-1:0]        gain_deriv_i,
  input  logic [gapc_pkg::SpeedW-1:0]       speed_limit_i,
  output logic signed [gapc_pkg::VelW-1:0]  vel_o
);

  logic signed [gapc_pkg::PropW-1:0] prop_q, prop_d;
  logic signed [gapc_pkg::DerW-1:0]  der_q, der_d;
  logic signed [gapc_pkg::IntW-1:0]  int_q, int_d;
  logic signed [gapc_pkg::AccW-1:0]  acc, lim_pos, lim_neg;
  logic signed [gapc_pkg::VelW-1:0]  vel_q, vel_d;

  // gains are unsigned: a zero sign bit keeps the signed multiply honest
  assign prop_d = signed'({1'b0, gain_prop_i}) * err_i;
  assign der_d  = signed'({1'b0, gain_deriv_i}) * derr_i;
  assign int_d  = signed'({1'b0, gain_integral_i}) * sum_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_prod) begin
      prop_q <= prop_d;
      der_q  <= der_d;
      int_q  <= int_d;
    end
  end

  always_comb begin
    acc = gapc_pkg::AccW'(prop_q) + gapc_pkg::AccW'(der_q) + gapc_pkg::AccW'(int_q);
    lim_pos = signed'({{(gapc_pkg::AccW - gapc_pkg::SpeedW){1'b0}}, speed_limit_i});
    lim_neg = -lim_pos;
    if (acc > lim_pos) begin
      vel_d = lim_pos[gapc_pkg::VelW-1:0];
    end else if (acc < lim_neg) begin
      vel_d = lim_neg[gapc_pkg::VelW-1:0];
    end else begin
      vel_d = acc[gapc_pkg::VelW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      vel_q <= vel_d;
    end
  end

  assign vel_o = vel_q;

endmodule

// ----- sv/gapc_checker.sv -----
// Port-level checks for the gap aiming PID controller, bound to the top level.
// Depends on gapc_pkg, gapc_in_if and gapc_out_if.
module gapc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  gapc_in_if.sink    target_i,
  gapc_out_if.source result_o
);

  // a stalled result holds its place and its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |=>
      result_o.valid && $stable(result_o.flight_mode) && $stable(result_o.vel_forward)
      && $stable(result_o.vel_lateral) && $stable(result_o.vel_vertical))
    else $error("result changed while stalled");

  // input back-pressure only arises from a stalled output
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !target_i.ready |-> result_o.valid && !result_o.ready)
    else $error("input stalled with output free");

  a_hover_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.flight_mode == gapc_pkg::MODE_HOVER |->
      result_o.vel_forward == '0 && result_o.vel_lateral == '0
      && result_o.vel_vertical == '0)
    else $error("hover with nonzero velocity");

  a_aim_no_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.flight_mode == gapc_pkg::MODE_AIM |->
      result_o.vel_forward == '0)
    else $error("forward speed while aiming");

  a_fly_no_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.flight_mode == gapc_pkg::MODE_FLY |->
      result_o.vel_lateral == '0 && result_o.vel_vertical == '0)
    else $error("side velocity while flying through");

endmodule

bind gap_aim_pid_controller_core gapc_checker u_gapc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .target_i (target_i),
  .result_o (result_o)
);
